FILE: rtl/mpsp_pkg.sv
// shared types, character codes and result codes for the motif pattern parser
package mpsp_pkg;

   localparam int NUMBER_BITS_DEFAULT = 8;

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_LBR   = 8'h5B;
   localparam logic [7:0] CH_RBR   = 8'h5D;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_Z     = 8'h5A;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;

   localparam logic [1:0] STATUS_OK           = 2'd0;
   localparam logic [1:0] STATUS_BAD_WILDCARD = 2'd1;
   localparam logic [1:0] STATUS_BAD_RESIDUE  = 2'd2;

   localparam int DATA_BITS = 72;

   typedef struct packed {
      logic       is_nl;
      logic       is_x;
      logic       is_open;
      logic       is_close;
      logic       is_comma;
      logic       is_dash;
      logic       is_lbr;
      logic       is_rbr;
      logic       is_upper;
      logic       is_digit;
      logic [4:0] letter;
      logic [3:0] digit;
   } char_info_type;

   typedef struct packed {
      logic          valid;
      char_info_type info;
   } char_stage_type;

   typedef struct packed {
      logic [7:0]  min_gap;
      logic [7:0]  extra_gap;
      logic [25:0] residue_mask;
      logic        is_class;
      logic [7:0]  component_index;
      logic [15:0] pattern_length;
      logic [1:0]  status;
      logic        last_of_pattern;
   } result_type;

endpackage

FILE: rtl/mpsp_char_class.sv
// input register that decodes each character into its class flags
module mpsp_char_class
   import mpsp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [7:0]     req_tdata,
   input  logic           advance,
   output char_stage_type stage
);

   logic          valid_ff, valid_in;
   char_info_type info_ff, info_in;

   assign req_tready = !valid_ff || advance;

   always_comb begin
      info_in.is_nl    = (req_tdata == CH_NL);
      info_in.is_x     = (req_tdata == CH_X);
      info_in.is_open  = (req_tdata == CH_OPEN);
      info_in.is_close = (req_tdata == CH_CLOSE);
      info_in.is_comma = (req_tdata == CH_COMMA);
      info_in.is_dash  = (req_tdata == CH_DASH);
      info_in.is_lbr   = (req_tdata == CH_LBR);
      info_in.is_rbr   = (req_tdata == CH_RBR);
      info_in.is_upper = req_tdata inside {[CH_A:CH_Z]};
      info_in.is_digit = req_tdata inside {[CH_0:CH_9]};
      info_in.letter   = 5'(req_tdata - CH_A);
      info_in.digit    = 4'(req_tdata - CH_0);
      valid_in         = req_tready ? req_tvalid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         info_ff <= info_in;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.info  = info_ff;

endmodule

FILE: rtl/mpsp_parser.sv
// parse state machine and result register
module mpsp_parser
   import mpsp_pkg::*;
#(
   parameter int NUMBER_BITS = NUMBER_BITS_DEFAULT
)
(
   input  logic           clock,
   input  logic           reset,
   input  char_stage_type stage,
   output logic           advance,
   output logic           out_valid,
   input  logic           out_ready,
   output result_type     out_data
);

   localparam int NUM_W = (NUMBER_BITS < 8) ? NUMBER_BITS : 8;
   localparam int SUM_W = NUM_W + 4;
   localparam logic [SUM_W-1:0] NUM_LIMIT = SUM_W'((1 << NUM_W) - 1);

   typedef enum logic [3:0] {
      PH_START, PH_WX, PH_OPEN1, PH_NUM1, PH_OPEN2, PH_NUM2,
      PH_CLOSE, PH_ITEM, PH_CLASS, PH_SEP
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [NUM_W-1:0]  lower_ff, lower_in;
   logic [NUM_W-1:0]  upper_ff, upper_in;
   logic [NUM_W-1:0]  gap_ff, gap_in;
   logic [NUM_W-1:0]  flex_ff, flex_in;
   logic [25:0]       class_ff, class_in;
   logic              seen_ff, seen_in;
   logic [15:0]       length_ff, length_in;
   logic [7:0]        count_ff, count_in;
   logic              skip_ff, skip_in;
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff, out_in;

   char_info_type     c;
   logic [SUM_W-1:0]  sum_lower, sum_upper;
   logic [17:0]       len_sum;
   logic [25:0]       letter_bit;
   logic              err, err_nl, fin, fin_nl, clear_all, emit;
   logic [1:0]        err_code;

   assign advance = stage.valid && (!out_valid_ff || out_ready);
   assign c       = stage.info;

   always_comb begin
      sum_lower  = SUM_W'(lower_ff) * SUM_W'(4'd10) + SUM_W'(c.digit);
      sum_upper  = SUM_W'(upper_ff) * SUM_W'(4'd10) + SUM_W'(c.digit);
      len_sum    = 18'(length_ff) + 18'd1 + 18'(gap_ff) + 18'(flex_ff);
      letter_bit = 26'd1 << c.letter;

      phase_in  = phase_ff;
      lower_in  = lower_ff;
      upper_in  = upper_ff;
      gap_in    = gap_ff;
      flex_in   = flex_ff;
      class_in  = class_ff;
      seen_in   = seen_ff;
      length_in = length_ff;
      count_in  = count_ff;
      skip_in   = skip_ff;
      out_in    = out_ff;
      err       = 1'b0;
      err_nl    = 1'b0;
      err_code  = STATUS_OK;
      fin       = 1'b0;
      fin_nl    = 1'b0;
      clear_all = 1'b0;

      if (advance) begin
         if (skip_ff) begin
            clear_all = c.is_nl;
         end else begin
            case (phase_ff)
               PH_START, PH_ITEM: begin
                  if (phase_ff == PH_START && c.is_nl) begin
                     if (count_ff == 8'd0) begin
                        clear_all = 1'b1;
                     end else begin
                        err = 1'b1; err_code = STATUS_BAD_RESIDUE; err_nl = 1'b1;
                     end
                  end else if (c.is_nl) begin
                     // newline where a residue must follow a wildcard
                     err = 1'b1; err_code = STATUS_BAD_WILDCARD; err_nl = 1'b1;
                  end else if (phase_ff == PH_START && c.is_x) begin
                     phase_in = PH_WX;
                  end else if (c.is_upper) begin
                     class_in = letter_bit;
                     seen_in  = 1'b0;
                     phase_in = PH_SEP;
                  end else if (c.is_lbr) begin
                     class_in = '0;
                     seen_in  = 1'b1;
                     phase_in = PH_CLASS;
                  end else begin
                     err = 1'b1; err_code = STATUS_BAD_RESIDUE;
                  end
               end
               PH_WX: begin
                  if (c.is_dash) begin
                     gap_in   = NUM_W'(1);
                     flex_in  = '0;
                     phase_in = PH_ITEM;
                  end else if (c.is_open) begin
                     lower_in = '0;
                     phase_in = PH_OPEN1;
                  end else begin
                     err = 1'b1; err_code = STATUS_BAD_WILDCARD; err_nl = c.is_nl;
                  end
               end
               PH_OPEN1, PH_NUM1: begin
                  if (c.is_digit) begin
                     if (sum_lower > NUM_LIMIT) begin
                        err = 1'b1; err_code = STATUS_BAD_WILDCARD;
                     end else begin
                        lower_in = NUM_W'(sum_lower);
                        phase_in = PH_NUM1;
                     end
                  end else if (phase_ff == PH_NUM1 && c.is_comma) begin
                     upper_in = '0;
                     phase_in = PH_OPEN2;
                  end else if (phase_ff == PH_NUM1 && c.is_close) begin
                     gap_in   = lower_ff;
                     flex_in  = '0;
                     phase_in = PH_CLOSE;
                  end else begin
                     err = 1'b1; err_code = STATUS_BAD_WILDCARD; err_nl = c.is_nl;
                  end
               end
               PH_OPEN2, PH_NUM2: begin
                  if (c.is_digit) begin
                     if (sum_upper > NUM_LIMIT) begin
                        err = 1'b1; err_code = STATUS_BAD_WILDCARD;
                     end else begin
                        upper_in = NUM_W'(sum_upper);
                        phase_in = PH_NUM2;
                     end
                  end else if (phase_ff == PH_NUM2 && c.is_close) begin
                     if (upper_ff < lower_ff) begin
                        err = 1'b1; err_code = STATUS_BAD_WILDCARD;
                     end else begin
                        gap_in   = lower_ff;
                        flex_in  = upper_ff - lower_ff;
                        phase_in = PH_CLOSE;
                     end
                  end else begin
                     err = 1'b1; err_code = STATUS_BAD_WILDCARD; err_nl = c.is_nl;
                  end
               end
               PH_CLOSE: begin
                  if (c.is_dash) begin
                     phase_in = PH_ITEM;
                  end else begin
                     err = 1'b1; err_code = STATUS_BAD_WILDCARD; err_nl = c.is_nl;
                  end
               end
               PH_CLASS: begin
                  if (c.is_upper) begin
                     class_in = class_ff | letter_bit;
                  end else if (c.is_rbr && class_ff != 26'd0) begin
                     phase_in = PH_SEP;
                  end else begin
                     err = 1'b1; err_code = STATUS_BAD_RESIDUE; err_nl = c.is_nl;
                  end
               end
               PH_SEP: begin
                  if (c.is_dash || c.is_nl) begin
                     fin    = 1'b1;
                     fin_nl = c.is_nl;
                  end else begin
                     err = 1'b1; err_code = STATUS_BAD_RESIDUE;
                  end
               end
               default: begin
                  err = 1'b1; err_code = STATUS_BAD_RESIDUE; err_nl = c.is_nl;
               end
            endcase
         end
      end

      emit = err || fin;

      if (err) begin
         out_in.min_gap         = '0;
         out_in.extra_gap       = '0;
         out_in.residue_mask    = '0;
         out_in.is_class        = 1'b0;
         out_in.component_index = count_ff;
         out_in.pattern_length  = length_ff;
         out_in.status          = err_code;
         out_in.last_of_pattern = 1'b1;
         skip_in                = !err_nl;
         clear_all              = err_nl;
      end

      if (fin) begin
         out_in.min_gap         = 8'(gap_ff);
         out_in.extra_gap       = 8'(flex_ff);
         out_in.residue_mask    = class_ff;
         out_in.is_class        = seen_ff;
         out_in.component_index = count_ff;
         // saturate the running length at the field maximum
         out_in.pattern_length  = (len_sum > 18'hFFFF) ? 16'hFFFF : len_sum[15:0];
         out_in.status          = STATUS_OK;
         out_in.last_of_pattern = fin_nl;
         length_in              = out_in.pattern_length;
         count_in               = count_ff + 8'd1;
         clear_all              = fin_nl;
      end

      if (err || fin) begin
         phase_in = PH_START;
         lower_in = '0;
         upper_in = '0;
         gap_in   = '0;
         flex_in  = '0;
         class_in = '0;
         seen_in  = 1'b0;
      end

      if (clear_all) begin
         phase_in  = PH_START;
         lower_in  = '0;
         upper_in  = '0;
         gap_in    = '0;
         flex_in   = '0;
         class_in  = '0;
         seen_in   = 1'b0;
         length_in = '0;
         count_in  = '0;
         skip_in   = 1'b0;
      end

      out_valid_in = advance ? emit : (out_valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         lower_ff     <= '0;
         upper_ff     <= '0;
         gap_ff       <= '0;
         flex_ff      <= '0;
         class_ff     <= '0;
         seen_ff      <= 1'b0;
         length_ff    <= '0;
         count_ff     <= '0;
         skip_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         out_ff       <= '0;
      end else begin
         phase_ff     <= phase_in;
         lower_ff     <= lower_in;
         upper_ff     <= upper_in;
         gap_ff       <= gap_in;
         flex_ff      <= flex_in;
         class_ff     <= class_in;
         seen_ff      <= seen_in;
         length_ff    <= length_in;
         count_ff     <= count_in;
         skip_ff      <= skip_in;
         out_valid_ff <= out_valid_in;
         out_ff       <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

`ifndef SYNTHESIS
   a_skip_at_start: assert property (@(posedge clock) disable iff (reset)
      skip_ff |-> phase_ff == PH_START)
      else $error("skipping while a component is open");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.status != STATUS_OK |-> out_ff.last_of_pattern)
      else $error("error word does not end the pattern");

   a_error_mask_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.status != STATUS_OK |-> out_ff.residue_mask == 26'd0)
      else $error("error word carries a residue mask");

   a_ok_mask_set: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.status == STATUS_OK |-> out_ff.residue_mask != 26'd0)
      else $error("component word with empty residue mask");

   a_skip_after_error: assert property (@(posedge clock) disable iff (reset)
      advance && err && !err_nl |=> skip_ff)
      else $error("skip not armed after error");
`endif

endmodule

FILE: rtl/motif_pattern_string_parser_top.sv
// path: a character waits in the input register, then the parser registers any result word
// throughput: one character per unstalled cycle; single-pass parse between two registers
// a stalled result holds the parser; the input register fills if empty, then waits
// reset: synchronous, active high; clears parse state, counters and both valid flags
// top level of the motif pattern parser
module motif_pattern_string_parser_top
   import mpsp_pkg::*;
#(
   parameter int NUMBER_BITS = NUMBER_BITS_DEFAULT
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // char_code
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // min_gap, extra_gap, residue_mask, is_class, component_index, pattern_length, status
   output logic [DATA_BITS-1:0] rsp_tdata,
   output logic                 rsp_tlast    // last_of_pattern
);

   char_stage_type stage;
   logic           advance;
   result_type     result;

   mpsp_char_class u_char_class (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .stage      (stage)
   );

   mpsp_parser #(
      .NUMBER_BITS (NUMBER_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .advance   (advance),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (result)
   );

   assign rsp_tdata = {3'b000, result.status, result.pattern_length, result.component_index,
                       result.is_class, result.residue_mask, result.extra_gap,
                       result.min_gap};
   assign rsp_tlast = result.last_of_pattern;

endmodule

FILE: bench/motif_pattern_checker.sv
// checker for the motif pattern parser: predicts result words from accepted characters
module motif_pattern_checker
   import mpsp_pkg::*;
#(
   parameter int NUMBER_BITS = NUMBER_BITS_DEFAULT
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [7:0]           req_tdata,   // char_code
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // min_gap, extra_gap, residue_mask, is_class, component_index, pattern_length, status
   input  logic [DATA_BITS-1:0] rsp_tdata,
   input  logic                 rsp_tlast,   // last_of_pattern
   output int                   fail_count,
   output int                   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUMBER_MAX = (NUMBER_BITS < 8) ? ((1 << NUMBER_BITS) - 1) : 255;

   typedef enum logic [3:0] {
      AT_START, AFTER_X, OPEN_LO, IN_LO, OPEN_HI, IN_HI,
      AFTER_CLOSE, AT_RESIDUE, IN_CLASS, AT_SEP
   } parse_phase_type;

   parse_phase_type phase;
   int              lower_num;
   int              upper_num;
   logic [25:0]     letter_mask;
   logic            in_class;
   logic [15:0]     total_len;
   logic [7:0]      comp_idx;
   logic            skipping;
   logic [7:0]      gap;
   logic [7:0]      flex;

   result_type   expected_words[$];

   initial fail_count = 0;

   task automatic report_mismatch(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      fail_count = fail_count + 1;
   endtask

   task automatic check_field(string name, int unsigned got, int unsigned want);
      if (got != want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   function automatic void next_component();
      phase       = AT_START;
      lower_num   = 0;
      upper_num   = 0;
      letter_mask = '0;
      in_class    = 1'b0;
      gap         = '0;
      flex        = '0;
   endfunction

   function automatic void clear_parser();
      next_component();
      total_len = '0;
      comp_idx  = '0;
      skipping  = 1'b0;
   endfunction

   function automatic void push_error(logic [1:0] code, logic at_nl);
      result_type r;
      r                 = '0;
      r.component_index = comp_idx;
      r.pattern_length  = total_len;
      r.status          = code;
      r.last_of_pattern = 1'b1;
      expected_words.push_back(r);
      if (at_nl) begin
         clear_parser();
      end else begin
         next_component();
         skipping = 1'b1;
      end
   endfunction

   function automatic void push_component(logic at_nl);
      int         sum;
      result_type r;
      sum = int'(total_len) + 1 + int'(gap) + int'(flex);
      if (sum > 65535)
         sum = 65535;
      total_len         = sum[15:0];
      r.min_gap         = gap;
      r.extra_gap       = flex;
      r.residue_mask    = letter_mask;
      r.is_class        = in_class;
      r.component_index = comp_idx;
      r.pattern_length  = total_len;
      r.status          = STATUS_OK;
      r.last_of_pattern = at_nl;
      expected_words.push_back(r);
      if (at_nl) begin
         clear_parser();
      end else begin
         comp_idx = comp_idx + 8'd1;
         next_component();
      end
   endfunction

   function automatic void take_residue(logic [7:0] c, logic up);
      if (up) begin
         letter_mask = 26'd1 << (c - CH_A);
         in_class    = 1'b0;
         phase       = AT_SEP;
      end else begin
         letter_mask = '0;
         in_class    = 1'b1;
         phase       = IN_CLASS;
      end
   endfunction

   function automatic void advance_parser(logic [7:0] c);
      logic nl;
      logic up;
      logic dig;
      int   v;
      nl  = (c == CH_NL);
      up  = c inside {[CH_A:CH_Z]};
      dig = c inside {[CH_0:CH_9]};
      if (skipping) begin
         if (nl)
            clear_parser();
         return;
      end
      case (phase)
         AT_START: begin
            if (nl) begin
               // empty line is silent, a trailing separator is not
               if (comp_idx == 8'd0)
                  clear_parser();
               else
                  push_error(STATUS_BAD_RESIDUE, 1'b1);
            end else if (c == CH_X) begin
               phase = AFTER_X;
            end else if (up || c == CH_LBR) begin
               take_residue(c, up);
            end else begin
               push_error(STATUS_BAD_RESIDUE, 1'b0);
            end
         end
         AFTER_X: begin
            if (c == CH_DASH) begin
               gap   = 8'd1;
               flex  = '0;
               phase = AT_RESIDUE;
            end else if (c == CH_OPEN) begin
               lower_num = 0;
               phase     = OPEN_LO;
            end else begin
               push_error(STATUS_BAD_WILDCARD, nl);
            end
         end
         OPEN_LO, IN_LO: begin
            if (dig) begin
               v = lower_num * 10 + (int'(c) - int'(CH_0));
               if (v > NUMBER_MAX) begin
                  push_error(STATUS_BAD_WILDCARD, 1'b0);
               end else begin
                  lower_num = v;
                  phase     = IN_LO;
               end
            end else if (phase == IN_LO && c == CH_COMMA) begin
               upper_num = 0;
               phase     = OPEN_HI;
            end else if (phase == IN_LO && c == CH_CLOSE) begin
               gap   = lower_num[7:0];
               flex  = '0;
               phase = AFTER_CLOSE;
            end else begin
               push_error(STATUS_BAD_WILDCARD, nl);
            end
         end
         OPEN_HI, IN_HI: begin
            if (dig) begin
               v = upper_num * 10 + (int'(c) - int'(CH_0));
               if (v > NUMBER_MAX) begin
                  push_error(STATUS_BAD_WILDCARD, 1'b0);
               end else begin
                  upper_num = v;
                  phase     = IN_HI;
               end
            end else if (phase == IN_HI && c == CH_CLOSE) begin
               if (upper_num < lower_num) begin
                  push_error(STATUS_BAD_WILDCARD, 1'b0);
               end else begin
                  gap   = lower_num[7:0];
                  v     = upper_num - lower_num;
                  flex  = v[7:0];
                  phase = AFTER_CLOSE;
               end
            end else begin
               push_error(STATUS_BAD_WILDCARD, nl);
            end
         end
         AFTER_CLOSE: begin
            if (c == CH_DASH)
               phase = AT_RESIDUE;
            else
               push_error(STATUS_BAD_WILDCARD, nl);
         end
         AT_RESIDUE: begin
            // newline here means the pattern ended on a wildcard
            if (nl)
               push_error(STATUS_BAD_WILDCARD, 1'b1);
            else if (up || c == CH_LBR)
               take_residue(c, up);
            else
               push_error(STATUS_BAD_RESIDUE, 1'b0);
         end
         IN_CLASS: begin
            if (up)
               letter_mask = letter_mask | (26'd1 << (c - CH_A));
            else if (c == CH_RBR && letter_mask != '0)
               phase = AT_SEP;
            else
               push_error(STATUS_BAD_RESIDUE, nl);
         end
         AT_SEP: begin
            if (c == CH_DASH)
               push_component(1'b0);
            else if (nl)
               push_component(1'b1);
            else
               push_error(STATUS_BAD_RESIDUE, 1'b0);
         end
         default: push_error(STATUS_BAD_RESIDUE, nl);
      endcase
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         expected_words.delete();
         clear_parser();
      end else begin
         // older results leave before the new character is predicted
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("result word %0h with nothing expected", rsp_tdata));
            end else begin
               want = expected_words.pop_front();
               // word layout from bit 0: gap 8, extra 8, mask 26, class 1, index 8,
               // length 16, status 2, zero fill 3
               check_field("min_gap", 32'(rsp_tdata[7:0]), 32'(want.min_gap));
               check_field("extra_gap", 32'(rsp_tdata[15:8]), 32'(want.extra_gap));
               check_field("residue_mask", 32'(rsp_tdata[41:16]), 32'(want.residue_mask));
               check_field("is_class", 32'(rsp_tdata[42]), 32'(want.is_class));
               check_field("component_index", 32'(rsp_tdata[50:43]),
                           32'(want.component_index));
               check_field("pattern_length", 32'(rsp_tdata[66:51]),
                           32'(want.pattern_length));
               check_field("status", 32'(rsp_tdata[68:67]), 32'(want.status));
               check_field("zero fill", 32'(rsp_tdata[71:69]), 0);
               check_field("last_of_pattern", 32'(rsp_tlast), 32'(want.last_of_pattern));
            end
         end
         if (req_tvalid && req_tready)
            advance_parser(req_tdata);
      end
      outstanding <= expected_words.size();
   end

endmodule

FILE: bench/tb.sv
// testbench top for the motif pattern parser: character stimulus, flow control, verdict
module tb
   import mpsp_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;
   localparam int QUIET_TAIL  = 60;
   localparam int ITEM_TARGET = 500;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_BITS-1:0] rsp_tdata;
   logic                 rsp_tlast;
   int                   fail_count;
   int                   outstanding;
   int                   stall_cycles = 0;
   logic                 calm = 1'b0;

   logic [7:0]           pattern_text[$];
   logic [7:0]           line_buf[$];

   motif_pattern_string_parser_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   motif_pattern_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   task automatic put_text(string s);
      for (int k = 0; k < s.len(); k++)
         pattern_text.push_back(s[k]);
   endtask

   task automatic append_line();
      foreach (line_buf[k])
         pattern_text.push_back(line_buf[k]);
   endtask

   function automatic int pick_number();
      case ($urandom_range(0, 3))
         0:       return 255;
         1:       return $urandom_range(0, 255);
         default: return $urandom_range(0, 12);
      endcase
   endfunction

   task automatic put_number(int n);
      string s;
      if ($urandom_range(0, 7) == 0)
         line_buf.push_back(CH_0);
      s = $sformatf("%0d", n);
      for (int k = 0; k < s.len(); k++)
         line_buf.push_back(s[k]);
   endtask

   function automatic logic [7:0] random_letter();
      return CH_A + 8'($urandom_range(0, 25));
   endfunction

   // characters that tend to land on a parser decision
   function automatic logic [7:0] tricky_char();
      case ($urandom_range(0, 10))
         0:       return CH_X;
         1:       return CH_OPEN;
         2:       return CH_CLOSE;
         3:       return CH_COMMA;
         4:       return CH_DASH;
         5:       return CH_LBR;
         6:       return CH_RBR;
         7:       return CH_NL;
         8:       return CH_0 + 8'($urandom_range(0, 9));
         9:       return random_letter();
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic build_line(int ncomp);
      int lo;
      int hi;
      int nlet;
      line_buf.delete();
      for (int i = 0; i < ncomp; i++) begin
         if (i > 0)
            line_buf.push_back(CH_DASH);
         case ($urandom_range(0, 4))
            1: begin
               line_buf.push_back(CH_X);
               line_buf.push_back(CH_DASH);
            end
            2: begin
               line_buf.push_back(CH_X);
               line_buf.push_back(CH_OPEN);
               put_number(pick_number());
               line_buf.push_back(CH_CLOSE);
               line_buf.push_back(CH_DASH);
            end
            3: begin
               lo = pick_number();
               hi = lo + $urandom_range(0, 255 - lo);
               line_buf.push_back(CH_X);
               line_buf.push_back(CH_OPEN);
               put_number(lo);
               line_buf.push_back(CH_COMMA);
               put_number(hi);
               line_buf.push_back(CH_CLOSE);
               line_buf.push_back(CH_DASH);
            end
            default: ;
         endcase
         if ($urandom_range(0, 2) == 0) begin
            nlet = $urandom_range(1, 4);
            line_buf.push_back(CH_LBR);
            repeat (nlet) line_buf.push_back(random_letter());
            line_buf.push_back(CH_RBR);
         end else begin
            line_buf.push_back(random_letter());
         end
      end
      line_buf.push_back(CH_NL);
   endtask

   // one edit somewhere before the closing newline
   task automatic corrupt_line();
      int pos;
      pos = $urandom_range(0, line_buf.size() - 2);
      case ($urandom_range(0, 3))
         0: line_buf[pos] = tricky_char();
         1: line_buf.insert(pos, tricky_char());
         2: line_buf.delete(pos);
         default: begin
            line_buf[pos] = CH_NL;
            while (line_buf.size() > pos + 1)
               void'(line_buf.pop_back());
         end
      endcase
   endtask

   task automatic add_random_line();
      int kind;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         pattern_text.push_back(CH_NL);
      end else if (kind == 1) begin
         repeat ($urandom_range(1, 6)) pattern_text.push_back(8'($urandom_range(0, 255)));
         pattern_text.push_back(CH_NL);
      end else begin
         build_line($urandom_range(1, 6));
         if (kind < 4)
            corrupt_line();
         append_line();
      end
   endtask

   initial begin
      // directed lines: extremes and each error path
      put_text("\n");
      put_text("x(0,255)-[AZ]-x-Y-x(007)-M\n");
      put_text("x(3,2)-A\n");
      put_text("x(256)-A\n");
      put_text("x()-A\n");
      put_text("x(4)A\n");
      put_text("x(2)\n");
      put_text("x-\n");
      put_text("x\n");
      put_text("[]-A\n");
      put_text("[A1]\n");
      put_text("[AB\n");
      put_text("AB\n");
      put_text("A-\n");
      put_text("a\n");
      while (pattern_text.size() < ITEM_TARGET)
         add_random_line();

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < pattern_text.size(); i++) begin
         calm = (i >= pattern_text.size() - QUIET_TAIL) || ((i / 64) % 3 == 0);
         if (!calm && $urandom_range(0, 3) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= pattern_text[i];
         do @(posedge clock); while (!req_tready);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   initial begin
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

endmodule

FILE: motif_pattern_string_parser_top.f
rtl/mpsp_pkg.sv
rtl/mpsp_char_class.sv
rtl/mpsp_parser.sv
rtl/motif_pattern_string_parser_top.sv
bench/motif_pattern_checker.sv
bench/tb.sv
